// ===== sv/rau_pkg.sv =====
package rau_pkg;

  // Default operand width and fixed result field widths
  localparam int DEF_OPERAND_WIDTH = 16;
  localparam int OPC_W             = 2;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 32;
  localparam int OUT_TDATA_W       = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;
  localparam int OUT_PAD_W         = OUT_TDATA_W - RES_NUM_W - RES_DEN_W;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  // Which product the shared multiplier forms this cycle
  typedef enum logic [1:0] {
    MSEL_P0,
    MSEL_P1,
    MSEL_P2
  } mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form;
    logic     gcd_init;
    logic     gcd_step;
    logic     gcd_fin;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_last;
  } sts_t;

endpackage

// ===== sv/rau_ctrl.sv =====
module rau_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  output logic          m_valid,
  input  logic          m_ready,
  output rau_pkg::cmd_t cmd,
  input  rau_pkg::sts_t sts
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    MUL0,
    MUL1,
    MUL2,
    FORM,
    CHECK,
    GCD,
    GSHIFT,
    DIV,
    DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_valid || m_ready;
  assign s_ready  = (state == IDLE);

  // Decode commands and next state
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MSEL_P0;
    state_next  = state;
    unique case (state)
      IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = MUL0;
        end
      end
      MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P0;
        state_next  = MUL1;
      end
      MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P1;
        state_next  = MUL2;
      end
      MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P2;
        state_next  = FORM;
      end
      FORM: begin
        cmd.form   = 1'b1;
        state_next = CHECK;
      end
      CHECK: begin
        if (sts.err) begin
          state_next = DONE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = GCD;
        end
      end
      GCD: begin
        if (sts.gcd_done) begin
          state_next = GSHIFT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      GSHIFT: begin
        cmd.gcd_fin = 1'b1;
        state_next  = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = DONE;
        end
      end
      DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/rau_dp.sv =====
module rau_dp #(
  parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                                clk,
  input  rau_pkg::cmd_t                       cmd,
  output rau_pkg::sts_t                       sts,
  input  rau_pkg::opcode_t                    opcode,
  input  logic signed [OPERAND_WIDTH-1:0]     a_num,
  input  logic signed [OPERAND_WIDTH-1:0]     a_den,
  input  logic signed [OPERAND_WIDTH-1:0]     b_num,
  input  logic signed [OPERAND_WIDTH-1:0]     b_den,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num,
  output logic signed [rau_pkg::RES_DEN_W-1:0] res_den,
  output logic                                zero_den_error
);
  import rau_pkg::*;

  // Product width, and working width (sum of two products, wrapping at 64 bits)
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int IW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
  localparam int KW = $clog2(IW);

  opcode_t                         op;
  logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  logic signed [OPERAND_WIDTH-1:0] mx, my;
  logic signed [PW-1:0]            prod, pa, pb;
  logic signed [IW-1:0]            num, den;
  logic signed [IW-1:0]            num_form;
  logic                            err;
  logic [IW-1:0]                   num_mag, den_mag;
  logic [IW-1:0]                   u, v, g, diff;
  logic [KW-1:0]                   k;
  logic [IW-1:0]                   qn, qd, rn, rd;
  logic [IW:0]                     sn, sd;
  logic                            bit_n, bit_d;
  logic [KW-1:0]                   cnt;
  logic signed [IW-1:0]            rnum, rden;

  // Capture operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
  end

  // Select the multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_P0: begin
        mx = an;
        my = (op == OP_MUL) ? bn : bd;
      end
      MSEL_P1: begin
        mx = bn;
        my = ad;
      end
      MSEL_P2: begin
        mx = ad;
        my = (op == OP_DIV) ? bn : bd;
      end
      default: begin
        mx = an;
        my = bd;
      end
    endcase
  end

  // Shared multiplier; earlier products shift down a two-entry history
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PW'(mx) * PW'(my);
      pa   <= prod;
      pb   <= pa;
    end
  end

  // Combine the cross products
  always_comb begin
    unique case (op)
      OP_ADD:  num_form = IW'(pb) + IW'(pa);
      OP_SUB:  num_form = IW'(pb) - IW'(pa);
      OP_MUL:  num_form = IW'(pb);
      OP_DIV:  num_form = IW'(pb);
      default: num_form = IW'(pb);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      num <= num_form;
      den <= IW'(prod);
      err <= (prod == '0);
    end
  end

  assign num_mag = num[IW-1] ? IW'(-num) : IW'(num);
  assign den_mag = den[IW-1] ? IW'(-den) : IW'(den);

  // Binary gcd: strip common twos into k, shift out lone twos, subtract odd pairs
  assign diff = u - v;

  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      u <= num_mag;
      v <= den_mag;
      k <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= diff;
      end else begin
        v <= IW'(-diff);
      end
    end
  end

  // Restoring division of both magnitudes by the gcd, one quotient bit a cycle
  assign sn    = {rn, qn[IW-1]};
  assign sd    = {rd, qd[IW-1]};
  assign bit_n = (sn >= {1'b0, g});
  assign bit_d = (sd >= {1'b0, g});

  always_ff @(posedge clk) begin
    if (cmd.gcd_fin) begin
      g   <= v << k;
      qn  <= num_mag;
      qd  <= den_mag;
      rn  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rn  <= bit_n ? IW'(sn - {1'b0, g}) : IW'(sn);
      rd  <= bit_d ? IW'(sd - {1'b0, g}) : IW'(sd);
      qn  <= {qn[IW-2:0], bit_n};
      qd  <= {qd[IW-2:0], bit_d};
      cnt <= cnt + 1'b1;
    end
  end

  // Restore the signs, or pass the raw fraction on error
  always_comb begin
    if (err) begin
      rnum = num;
      rden = den;
    end else begin
      rnum = num[IW-1] ? IW'(-qn) : IW'(qn);
      rden = den[IW-1] ? IW'(-qd) : IW'(qd);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num        <= RES_NUM_W'(rnum);
      res_den        <= RES_DEN_W'(rden);
      zero_den_error <= err;
    end
  end

  assign sts.err      = err;
  assign sts.gcd_done = (u == '0);
  assign sts.div_last = (cnt == KW'(IW - 1));

endmodule

// ===== sv/rational_arithmetic_unit_core.sv =====
// Channel   Direction  tdata (low bit up)                  tuser
// s_axis    in         a_num, a_den, b_num, b_den          opcode
// m_axis    out        res_num, res_den, zero pad          zero_den_error
//
// One transaction at a time. Per item, in order: accept, form the three products
// in turn on the shared multiplier, form and check, run the binary gcd loop until
// it finishes, shift, run IW division steps (IW = 2*OPERAND_WIDTH+1 capped at 64),
// then load the result register. An item with a zero denominator skips the gcd
// and division.
// Synchronous reset clears the controller and the output valid. A new item is
// taken while a result waits in the output register; the block stalls in its
// last step only if that register is still full.
module rational_arithmetic_unit_core #(
  parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                s_axis_tvalid,
  output logic                                                s_axis_tready,
  // a_num, a_den, b_num, b_den, zero pad
  input  logic [((4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0]     s_axis_tdata,
  // opcode
  input  logic [rau_pkg::OPC_W-1:0]                           s_axis_tuser,
  output logic                                                m_axis_tvalid,
  input  logic                                                m_axis_tready,
  // res_num, res_den, zero pad
  output logic [rau_pkg::OUT_TDATA_W-1:0]                     m_axis_tdata,
  // zero_den_error
  output logic                                                m_axis_tuser
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  cmd_t                  cmd;
  sts_t                  sts;
  logic signed [RES_NUM_W-1:0] res_num;
  logic signed [RES_DEN_W-1:0] res_den;

  rau_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  rau_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (opcode_t'(s_axis_tuser)),
    .a_num          (s_axis_tdata[W-1:0]),
    .a_den          (s_axis_tdata[2*W-1:W]),
    .b_num          (s_axis_tdata[3*W-1:2*W]),
    .b_den          (s_axis_tdata[4*W-1:3*W]),
    .res_num        (res_num),
    .res_den        (res_den),
    .zero_den_error (m_axis_tuser)
  );

  // Pack the result fields
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_den, res_num};

endmodule

// ===== verif/rational_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 100ps

module rational_arithmetic_unit_core_tb;
  import rau_pkg::*;

  localparam int OPW        = DEF_OPERAND_WIDTH;
  localparam int IN_TDATA_W = ((4 * OPW + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 1400;

  // One pair of fractions with its operation; drain holds it until the block is empty
  typedef struct {
    opcode_t               op;
    logic signed [OPW-1:0] a_num;
    logic signed [OPW-1:0] a_den;
    logic signed [OPW-1:0] b_num;
    logic signed [OPW-1:0] b_den;
    bit                    drain;
  } frac_op_t;

  typedef struct {
    logic [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0] den;
    logic                 err;
  } frac_res_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OPC_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  frac_op_t  pending_ops[$];
  frac_res_t expected_fracs[$];
  frac_op_t  next_op;
  frac_op_t  taken_op;
  frac_res_t want;
  logic      in_fire = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        ready_mode = 0;
  int        mode_cycles = 0;
  int        idle_cycles = 0;
  int        fail_count = 0;

  rational_arithmetic_unit_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cross-multiply, then reduce by the gcd of the magnitudes unless den is zero
  function automatic frac_res_t predict_frac(frac_op_t it);
    longint    an, ad, bn, bd, num, den, x, y, r;
    frac_res_t res;
    an = it.a_num;
    ad = it.a_den;
    bn = it.b_num;
    bd = it.b_den;
    case (it.op)
      OP_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      OP_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    res.err = 1'b0;
    if (den == 0) begin
      res.err = 1'b1;
    end else begin
      x = (num < 0) ? -num : num;
      y = (den < 0) ? -den : den;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      // Signed divide truncates toward zero, so each part keeps its sign
      num = num / x;
      den = den / x;
    end
    res.num = RES_NUM_W'(num);
    res.den = RES_DEN_W'(den);
    return res;
  endfunction

  // Mix full-range values, small values with common factors, extremes and powers of two
  function automatic logic [OPW-1:0] rand_operand(bit is_den);
    int v;
    int k;
    if (is_den && $urandom_range(0, 24) == 0) return '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7: begin
        v = $urandom_range(0, 40);
        v = v - 20;
      end
      8: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          default: v = 32767;
        endcase
      end
      default: begin
        k = $urandom_range(0, 14);
        v = 1 << k;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v[OPW-1:0];
  endfunction

  task automatic queue_op(opcode_t op, int an, int ad, int bn, int bd, bit drain);
    frac_op_t it;
    it.op    = op;
    it.a_num = an[OPW-1:0];
    it.a_den = ad[OPW-1:0];
    it.b_num = bn[OPW-1:0];
    it.b_den = bd[OPW-1:0];
    it.drain = drain;
    pending_ops.push_back(it);
  endtask

  // Stimulus, reset and end of run
  initial begin
    // Extremes on every operation
    queue_op(OP_ADD, -32768, -32768, -32768, -32768, 1'b0);
    queue_op(OP_SUB, -32768, -32768, -32768, -32768, 1'b0);
    queue_op(OP_MUL, -32768, -32768, -32768, -32768, 1'b0);
    queue_op(OP_DIV, -32768, -32768, -32768, -32768, 1'b0);
    queue_op(OP_ADD, 32767, 32767, 32767, 32767, 1'b0);
    queue_op(OP_SUB, 32767, -32768, -32768, 32767, 1'b0);
    queue_op(OP_MUL, 32767, -32768, 32767, -32768, 1'b0);
    queue_op(OP_DIV, -32768, 32767, 32767, -32768, 1'b0);
    queue_op(OP_ADD, -32768, 1, -32768, 1, 1'b0);
    // Zero result denominator on each path
    queue_op(OP_ADD, 5, 0, 3, 7, 1'b0);
    queue_op(OP_SUB, -32768, 9, 32767, 0, 1'b0);
    queue_op(OP_MUL, 32767, 0, -32768, 0, 1'b0);
    queue_op(OP_DIV, -32768, 3, 0, -32768, 1'b0);
    queue_op(OP_DIV, 0, 0, 0, 0, 1'b0);
    // Zero numerator reduces to 0 over +1 or -1
    queue_op(OP_ADD, 0, -6, 0, 4, 1'b0);
    queue_op(OP_SUB, 3, 4, 3, 4, 1'b0);
    queue_op(OP_MUL, 0, 12, 7, 9, 1'b0);
    queue_op(OP_DIV, 0, -5, 3, 2, 1'b0);
    // Ordinary fractions with mixed signs and common factors
    queue_op(OP_ADD, 1, 2, 1, 3, 1'b1);
    queue_op(OP_SUB, -6, 8, 10, -4, 1'b0);
    queue_op(OP_MUL, 12, -18, -9, 6, 1'b0);
    queue_op(OP_DIV, 21, 14, -35, 10, 1'b0);
    queue_op(OP_DIV, -1, -1, -1, -1, 1'b0);
    queue_op(OP_MUL, 4096, 1024, -2048, 8192, 1'b0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      queue_op(opcode_t'($urandom_range(0, 3)),
               int'($signed(rand_operand(1'b0))), int'($signed(rand_operand(1'b1))),
               int'($signed(rand_operand(1'b0))), int'($signed(rand_operand(1'b1))),
               (i % 300) == 299);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all stimulus to go in, then for every result to drain out
    while (pending_ops.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_fracs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Present items in bursts with random gaps; hold drain items until the block is empty
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() == 0 ||
                   (pending_ops[0].drain && expected_fracs.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        next_op = pending_ops.pop_front();
        s_axis_tdata  <= {next_op.b_den, next_op.b_num, next_op.a_den, next_op.a_num};
        s_axis_tuser  <= next_op.op;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
        end
      end
    end
  end

  // Receiver: switch between always ready, coin-flip ready and long stalls
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode  = $urandom_range(0, 2);
      mode_cycles = $urandom_range(100, 600);
    end else begin
      mode_cycles--;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        default: begin
          if ($urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(1, 200);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Predict on input transactions, check output transactions, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      in_fire     <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;

      // Pop before push so a result never matches the item taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_fracs.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count++;
        end else begin
          want = expected_fracs.pop_front();
          if (m_axis_tdata[RES_NUM_W-1:0] !== want.num) begin
            $error("res_num: expected %0d, actual %0d", $signed(want.num),
                   $signed(m_axis_tdata[RES_NUM_W-1:0]));
            fail_count++;
          end
          if (m_axis_tdata[RES_NUM_W +: RES_DEN_W] !== want.den) begin
            $error("res_den: expected %0d, actual %0d", $signed(want.den),
                   $signed(m_axis_tdata[RES_NUM_W +: RES_DEN_W]));
            fail_count++;
          end
          if (m_axis_tuser !== want.err) begin
            $error("zero_den_error: expected %0b, actual %0b", want.err, m_axis_tuser);
            fail_count++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        taken_op.op    = opcode_t'(s_axis_tuser);
        taken_op.a_num = s_axis_tdata[0 +: OPW];
        taken_op.a_den = s_axis_tdata[OPW +: OPW];
        taken_op.b_num = s_axis_tdata[2 * OPW +: OPW];
        taken_op.b_den = s_axis_tdata[3 * OPW +: OPW];
        taken_op.drain = 1'b0;
        expected_fracs.push_back(predict_frac(taken_op));
      end

      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

endmodule
